### hw/rtl/mfo_pkg.sv
// ----------------------------------------------------------------------------
// Multi-channel overwrite FIFO package
// Operation codes, status codes, state encoding and fixed field widths.
// ----------------------------------------------------------------------------
package mfo_pkg;

    localparam int WORD_W     = 32;
    localparam int MODE_W     = 2;
    localparam int CHAN_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int MOVE_W     = 2;
    localparam int MOVE_LIMIT = 8;

    typedef enum logic [MODE_W-1:0] {
        MODE_WRITE = 2'd0,
        MODE_READ  = 2'd1,
        MODE_MOVE  = 2'd2,
        MODE_CLEAR = 2'd3
    } t_mode;

    localparam logic [STATUS_W-1:0] STS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STS_OVERWRITE = 2'd1;
    localparam logic [STATUS_W-1:0] STS_EMPTY     = 2'd2;

    localparam logic signed [MOVE_W-1:0] MOVE_NONE = 2'sb00;
    localparam logic signed [MOVE_W-1:0] MOVE_POS  = 2'sb01;
    localparam logic signed [MOVE_W-1:0] MOVE_NEG  = 2'sb11;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_EXEC,
        S_RDWAIT,
        S_SUM,
        S_SUMEND,
        S_DONE
    } t_state;

endpackage

### hw/rtl/mfo_in_if.sv
// ----------------------------------------------------------------------------
// Command channel interface
// Valid/ready channel that carries one FIFO operation per beat.
// ----------------------------------------------------------------------------
interface mfo_in_if import mfo_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [MODE_W-1:0]        mode;
    logic [CHAN_W-1:0]        channel;
    logic signed [WORD_W-1:0] write_data;

    modport source (output valid, output mode, output channel, output write_data,
                    input ready);
    modport sink   (input valid, input mode, input channel, input write_data,
                    output ready);
endinterface

### hw/rtl/mfo_out_if.sv
// ----------------------------------------------------------------------------
// Result channel interface
// Valid/ready channel that carries one operation result per beat.
// ----------------------------------------------------------------------------
interface mfo_out_if import mfo_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [WORD_W-1:0] read_data;
    logic [STATUS_W-1:0]      status;
    logic signed [MOVE_W-1:0] movement;
    logic [WORD_W-1:0]        lost_count;

    modport source (output valid, output read_data, output status, output movement,
                    output lost_count, input ready);
    modport sink   (input valid, input read_data, input status, input movement,
                    input lost_count, output ready);
endinterface

### hw/rtl/multi_channel_overwrite_fifo_top.sv
// ----------------------------------------------------------------------------
// Multi-channel overwrite FIFO
// CHANNELS circular FIFOs that hold up to DEPTH - 1 signed words and drop the
// oldest word when full, with a per-channel lost counter and a movement query
// over all DEPTH RAM slots of a channel.
// One command is processed at a time. A write, a clear or a read of an empty
// FIFO goes from S_EXEC to S_DONE, a read waits in S_RDWAIT for the registered
// RAM data, and a movement query passes through S_SUM and S_SUMEND while it
// fetches the DEPTH words of the channel one per cycle through the single RAM
// port into one shared adder. The result sits in an output register, so a new
// command can be accepted while the previous result waits to be taken. After
// reset a clearing pass writes zero to all CHANNELS rounded up to a power of
// two times DEPTH rounded up to a power of two RAM entries, one per cycle (64
// entries at the default sizes), and no command is accepted until it is done.
// ----------------------------------------------------------------------------
module multi_channel_overwrite_fifo_top import mfo_pkg::*; #(
    parameter int DEPTH    = 16,
    parameter int CHANNELS = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mfo_in_if.sink    i_in,
    mfo_out_if.source o_out
);

    localparam int IW     = $clog2(DEPTH);
    localparam int CW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CXW    = (CW > CHAN_W) ? CW : CHAN_W;
    localparam int AW     = CW + IW;
    localparam int SUM_W  = WORD_W + IW + 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);

    function automatic logic [IW-1:0] next_slot(input logic [IW-1:0] idx);
        return (idx == LAST_IDX) ? '0 : idx + 1'b1;
    endfunction

    t_state r_state;
    t_state n_state;

    logic [IW-1:0]     r_ri   [CHANNELS];
    logic [IW-1:0]     r_wi   [CHANNELS];
    logic [IW-1:0]     r_fill [CHANNELS];
    logic [WORD_W-1:0] r_lost [CHANNELS];

    t_mode                    r_mode;
    logic [CW-1:0]            r_ch;
    logic                     r_ch_ok;
    logic signed [WORD_W-1:0] r_wdata;
    logic [AW-1:0]            r_clr_addr;
    logic [IW-1:0]            r_cnt;
    logic [IW-1:0]            n_cnt;
    logic                     r_pend;
    logic                     n_pend;

    logic signed [WORD_W-1:0] r_res_rdata;
    logic signed [WORD_W-1:0] n_res_rdata;
    logic [STATUS_W-1:0]      r_res_status;
    logic [STATUS_W-1:0]      n_res_status;

    logic                     r_out_valid;
    logic signed [WORD_W-1:0] r_o_rdata;
    logic [STATUS_W-1:0]      r_o_status;
    logic signed [MOVE_W-1:0] r_o_move;
    logic [WORD_W-1:0]        r_o_lost;

    logic                     upd;
    logic [IW-1:0]            n_ri;
    logic [IW-1:0]            n_wi;
    logic [IW-1:0]            n_fill;
    logic [WORD_W-1:0]        n_lost;

    logic                     ram_we;
    logic [AW-1:0]            ram_addr;
    logic [WORD_W-1:0]        ram_wdata;
    logic [WORD_W-1:0]        ram_rdata;
    logic                     acc_clr;
    logic signed [SUM_W-1:0]  acc_sum;
    logic signed [MOVE_W-1:0] move_val;

    logic                     in_acc;
    logic                     out_load;
    logic [CXW-1:0]           in_ch_wide;
    logic                     in_ch_ok;

    assign in_acc     = i_in.valid && i_in.ready;
    assign in_ch_wide = CXW'(i_in.channel);
    assign in_ch_ok   = 32'(i_in.channel) < 32'(CHANNELS);
    assign out_load   = (r_state == S_DONE) && (!r_out_valid || o_out.ready);

    mfo_ram #(
        .WIDTH (WORD_W),
        .DEPTH (2 ** AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    mfo_accum #(
        .SUM_W (SUM_W)
    ) u_accum (
        .i_clk  (i_clk),
        .i_clr  (acc_clr),
        .i_en   (r_pend),
        .i_data ($signed(ram_rdata)),
        .o_sum  (acc_sum)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT: begin
                if (r_clr_addr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!r_ch_ok) begin
                    n_state = S_DONE;
                end else begin
                    case (r_mode)
                        MODE_READ: n_state = (r_fill[r_ch] == '0) ? S_DONE : S_RDWAIT;
                        MODE_MOVE: n_state = S_SUM;
                        default:   n_state = S_DONE;
                    endcase
                end
            end
            S_RDWAIT: n_state = S_DONE;
            S_SUM: begin
                if (r_cnt == LAST_IDX) begin
                    n_state = S_SUMEND;
                end
            end
            S_SUMEND: n_state = S_DONE;
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        ram_we       = 1'b0;
        ram_addr     = {r_ch, r_cnt};
        ram_wdata    = r_wdata;
        acc_clr      = 1'b0;
        n_pend       = 1'b0;
        n_cnt        = r_cnt;
        upd          = 1'b0;
        n_ri         = r_ri[r_ch];
        n_wi         = r_wi[r_ch];
        n_fill       = r_fill[r_ch];
        n_lost       = r_lost[r_ch];
        n_res_rdata  = r_res_rdata;
        n_res_status = r_res_status;
        case (r_state)
            S_INIT: begin
                ram_we    = 1'b1;
                ram_addr  = r_clr_addr;
                ram_wdata = '0;
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_res_rdata  = '0;
                    n_res_status = STS_OK;
                end
            end
            S_EXEC: begin
                if (r_ch_ok) begin
                    case (r_mode)
                        MODE_WRITE: begin
                            ram_we   = 1'b1;
                            ram_addr = {r_ch, r_wi[r_ch]};
                            upd      = 1'b1;
                            n_wi     = next_slot(r_wi[r_ch]);
                            if (r_fill[r_ch] == LAST_IDX) begin
                                n_lost       = r_lost[r_ch] + 1'b1;
                                n_ri         = next_slot(r_ri[r_ch]);
                                n_res_status = STS_OVERWRITE;
                            end else begin
                                n_fill = r_fill[r_ch] + 1'b1;
                            end
                        end
                        MODE_READ: begin
                            if (r_fill[r_ch] == '0) begin
                                n_res_status = STS_EMPTY;
                            end else begin
                                ram_addr = {r_ch, r_ri[r_ch]};
                                upd      = 1'b1;
                                n_ri     = next_slot(r_ri[r_ch]);
                                n_fill   = r_fill[r_ch] - 1'b1;
                            end
                        end
                        MODE_MOVE: begin
                            acc_clr = 1'b1;
                            n_cnt   = '0;
                        end
                        MODE_CLEAR: begin
                            upd    = 1'b1;
                            n_ri   = '0;
                            n_wi   = '0;
                            n_fill = '0;
                            n_lost = '0;
                        end
                        default: ;
                    endcase
                end
            end
            S_RDWAIT: n_res_rdata = $signed(ram_rdata);
            S_SUM: begin
                n_pend = 1'b1;
                n_cnt  = r_cnt + 1'b1;
            end
            default: ;
        endcase
    end

    always_comb begin
        move_val = MOVE_NONE;
        if (r_ch_ok && (r_mode == MODE_MOVE)) begin
            if (acc_sum > $signed(SUM_W'(MOVE_LIMIT))) begin
                move_val = MOVE_POS;
            end else if (acc_sum < -$signed(SUM_W'(MOVE_LIMIT))) begin
                move_val = MOVE_NEG;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_clr_addr  <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_ri[c]   <= '0;
                r_wi[c]   <= '0;
                r_fill[c] <= '0;
                r_lost[c] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
            if (r_state == S_INIT) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (upd) begin
                r_ri[r_ch]   <= n_ri;
                r_wi[r_ch]   <= n_wi;
                r_fill[r_ch] <= n_fill;
                r_lost[r_ch] <= n_lost;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt        <= n_cnt;
        r_res_rdata  <= n_res_rdata;
        r_res_status <= n_res_status;
        if (in_acc) begin
            r_mode  <= t_mode'(i_in.mode);
            r_ch    <= in_ch_wide[CW-1:0];
            r_ch_ok <= in_ch_ok;
            r_wdata <= i_in.write_data;
        end
        if (out_load) begin
            r_o_rdata  <= r_res_rdata;
            r_o_status <= r_res_status;
            r_o_move   <= move_val;
            r_o_lost   <= r_ch_ok ? r_lost[r_ch] : '0;
        end
    end

    assign i_in.ready       = (r_state == S_IDLE);
    assign o_out.valid      = r_out_valid;
    assign o_out.read_data  = r_o_rdata;
    assign o_out.status     = r_o_status;
    assign o_out.movement   = r_o_move;
    assign o_out.lost_count = r_o_lost;

    a_no_accept_in_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INIT) |-> !in_acc)
        else $error("Command accepted during the clearing pass.");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("Result register loaded outside the done state.");

    a_accum_in_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> ((r_state == S_SUM) || (r_state == S_SUMEND)))
        else $error("Accumulator enabled outside the movement sum.");

    a_sum_runs_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SUMEND) |-> ($past(r_cnt) == LAST_IDX))
        else $error("Movement sum ended before all words were fetched.");

endmodule

### hw/rtl/mfo_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One address per cycle, write or read, with registered read data.
// ----------------------------------------------------------------------------
module mfo_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/mfo_accum.sv
// ----------------------------------------------------------------------------
// Shared accumulator
// Adds one sign-extended word per enabled cycle into a wide running sum.
// ----------------------------------------------------------------------------
module mfo_accum import mfo_pkg::*; #(
    parameter int SUM_W = 37
) (
    input  logic                     i_clk,
    input  logic                     i_clr,
    input  logic                     i_en,
    input  logic signed [WORD_W-1:0] i_data,
    output logic signed [SUM_W-1:0]  o_sum
);

    logic signed [SUM_W-1:0] r_sum;
    logic signed [SUM_W-1:0] n_sum;

    always_comb begin
        n_sum = r_sum;
        if (i_clr) begin
            n_sum = '0;
        end else if (i_en) begin
            n_sum = r_sum + SUM_W'(i_data);
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum <= n_sum;
    end

    assign o_sum = r_sum;

endmodule

### dv/tb_multi_channel_overwrite_fifo_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Multi-channel overwrite FIFO testbench
// Sends a short table of directed commands, then random bursts of writes,
// reads, movement queries and clears. A behavioral copy of the four channels
// predicts the results that the table does not fix, and each result beat is
// compared field by field while both channels stall at random outside one run.
// ----------------------------------------------------------------------------
module tb_multi_channel_overwrite_fifo_top;
    import mfo_pkg::*;

    localparam int FIFO_DEPTH    = 16;
    localparam int FIFO_CHANS    = 4;
    localparam int RANDOM_BEATS  = 650;
    localparam int SETTLE_CYCLES = 2 * FIFO_DEPTH + 8;
    localparam int PLAN_ROWS     = 17;

    typedef struct packed {
        logic signed [WORD_W-1:0] read_data;
        logic [STATUS_W-1:0]      status;
        logic signed [MOVE_W-1:0] movement;
        logic [WORD_W-1:0]        lost_count;
    } t_fifo_reply;

    typedef struct packed {
        t_mode                    op;
        logic [CHAN_W-1:0]        chan;
        logic signed [WORD_W-1:0] word;
        logic [4:0]               reps;
        logic                     fixed;
        t_fifo_reply              reply;
    } t_plan_row;

    localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    localparam t_fifo_reply REPLY_QUIET = '{32'sd0, STS_OK, MOVE_NONE, 32'd0};
    localparam t_fifo_reply REPLY_EMPTY = '{32'sd0, STS_EMPTY, MOVE_NONE, 32'd0};

    logic i_clk = 1'b0;
    logic i_rst_n;
    bit   gaps_on = 1'b1;
    int   fault_count = 0;
    int   beats_sent = 0;

    logic signed [WORD_W-1:0] chan_words [FIFO_CHANS][FIFO_DEPTH];
    int unsigned              head_slot  [FIFO_CHANS];
    int unsigned              tail_slot  [FIFO_CHANS];
    int unsigned              fill_level [FIFO_CHANS];
    logic [WORD_W-1:0]        words_lost [FIFO_CHANS];
    t_fifo_reply              owed_replies [$];
    t_plan_row                opening_plan [PLAN_ROWS];

    mfo_in_if  cmd ();
    mfo_out_if rsp ();

    multi_channel_overwrite_fifo_top #(
        .DEPTH    (FIFO_DEPTH),
        .CHANNELS (FIFO_CHANS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd),
        .o_out   (rsp)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic flag_error(input string msg);
        fault_count++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    function automatic t_fifo_reply apply_fifo_op(input t_mode op,
                                                  input logic [CHAN_W-1:0] ch,
                                                  input logic signed [WORD_W-1:0] data);
        t_fifo_reply r;
        longint      total;
        r = '0;
        total = 0;
        case (op)
            MODE_WRITE: begin
                chan_words[ch][tail_slot[ch]] = data;
                tail_slot[ch] = (tail_slot[ch] + 1) % FIFO_DEPTH;
                if (fill_level[ch] == FIFO_DEPTH - 1) begin
                    head_slot[ch] = (head_slot[ch] + 1) % FIFO_DEPTH;
                    words_lost[ch] = words_lost[ch] + 1'b1;
                    r.status = STS_OVERWRITE;
                end else begin
                    fill_level[ch] = fill_level[ch] + 1;
                end
            end
            MODE_READ: begin
                if (fill_level[ch] == 0) begin
                    r.status = STS_EMPTY;
                end else begin
                    r.read_data = chan_words[ch][head_slot[ch]];
                    head_slot[ch] = (head_slot[ch] + 1) % FIFO_DEPTH;
                    fill_level[ch] = fill_level[ch] - 1;
                end
            end
            MODE_MOVE: begin
                for (int i = 0; i < FIFO_DEPTH; i++) begin
                    total += longint'(chan_words[ch][i]);
                end
                if (total > MOVE_LIMIT) begin
                    r.movement = MOVE_POS;
                end else if (total < -MOVE_LIMIT) begin
                    r.movement = MOVE_NEG;
                end
            end
            default: begin
                head_slot[ch] = 0;
                tail_slot[ch] = 0;
                fill_level[ch] = 0;
                words_lost[ch] = '0;
            end
        endcase
        r.lost_count = words_lost[ch];
        return r;
    endfunction

    function automatic logic signed [WORD_W-1:0] pick_word(input int unsigned style);
        int unsigned roll;
        roll = $urandom_range(0, 9);
        case (style)
            0: return $urandom_range(0, 4) - 2;
            1: return $urandom_range(0, 24) - 12;
            2: return (roll < 5) ? WORD_MAX : WORD_MIN;
            3: begin
                if (roll < 3) begin
                    return $urandom_range(0, 4) - 2;
                end else if (roll < 5) begin
                    return (roll == 3) ? WORD_MAX : WORD_MIN;
                end
                return $urandom;
            end
            default: return $urandom;
        endcase
    endfunction

    task automatic send_beat(input t_mode op, input logic [CHAN_W-1:0] ch,
                             input logic signed [WORD_W-1:0] data,
                             input bit fixed, input t_fifo_reply reply);
        t_fifo_reply predicted;
        bit          taken;
        while (gaps_on && $urandom_range(0, 99) < 22) begin
            cmd.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd.valid      <= 1'b1;
        cmd.mode       <= op;
        cmd.channel    <= ch;
        cmd.write_data <= data;
        do begin
            @(negedge i_clk);
            taken = cmd.ready;
            if (taken) begin
                predicted = apply_fifo_op(op, ch, data);
                owed_replies.push_back(fixed ? reply : predicted);
            end
            @(posedge i_clk);
        end while (!taken);
        beats_sent++;
    endtask

    // The result beat that is taken at the next rising edge is checked here.
    always @(negedge i_clk) begin
        t_fifo_reply want;
        if (i_rst_n === 1'b1 && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
            if (owed_replies.size() == 0) begin
                flag_error($sformatf("result beat with nothing pending, status %0d",
                                     rsp.status));
            end else begin
                want = owed_replies.pop_front();
                if (rsp.read_data !== want.read_data) begin
                    flag_error($sformatf("read_data got %0d want %0d",
                                         rsp.read_data, want.read_data));
                end
                if (rsp.status !== want.status) begin
                    flag_error($sformatf("status got %0d want %0d",
                                         rsp.status, want.status));
                end
                if (rsp.movement !== want.movement) begin
                    flag_error($sformatf("movement got %0d want %0d",
                                         rsp.movement, want.movement));
                end
                if (rsp.lost_count !== want.lost_count) begin
                    flag_error($sformatf("lost_count got %0d want %0d",
                                         rsp.lost_count, want.lost_count));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        rsp.ready <= gaps_on ? ($urandom_range(0, 99) >= 22) : 1'b1;
    end

    initial begin
        int          opening_beats;
        int          rel;
        int unsigned burst;
        int unsigned style;
        logic [CHAN_W-1:0] ch;
        t_mode       op;

        i_rst_n        <= 1'b0;
        cmd.valid      <= 1'b0;
        cmd.mode       <= MODE_WRITE;
        cmd.channel    <= '0;
        cmd.write_data <= '0;
        for (int c = 0; c < FIFO_CHANS; c++) begin
            head_slot[c] = 0;
            tail_slot[c] = 0;
            fill_level[c] = 0;
            words_lost[c] = '0;
            for (int i = 0; i < FIFO_DEPTH; i++) begin
                chan_words[c][i] = '0;
            end
        end

        opening_plan = '{
            '{MODE_READ,  2'd0, 32'sd0,       5'd1,  1'b1, REPLY_EMPTY},
            '{MODE_WRITE, 2'd0, WORD_MAX,     5'd1,  1'b1, REPLY_QUIET},
            '{MODE_WRITE, 2'd0, WORD_MIN,     5'd1,  1'b1, REPLY_QUIET},
            '{MODE_MOVE,  2'd0, 32'sd0,       5'd1,  1'b0, REPLY_QUIET},
            '{MODE_READ,  2'd0, 32'sd0,       5'd1,  1'b1,
              '{WORD_MAX, STS_OK, MOVE_NONE, 32'd0}},
            '{MODE_READ,  2'd0, 32'sd0,       5'd1,  1'b1,
              '{WORD_MIN, STS_OK, MOVE_NONE, 32'd0}},
            '{MODE_READ,  2'd0, 32'sd0,       5'd1,  1'b1, REPLY_EMPTY},
            '{MODE_WRITE, 2'd1, 32'sd9,       5'd1,  1'b0, REPLY_QUIET},
            '{MODE_MOVE,  2'd1, 32'sd0,       5'd1,  1'b0, REPLY_QUIET},
            '{MODE_WRITE, 2'd1, -32'sd18,     5'd1,  1'b0, REPLY_QUIET},
            '{MODE_MOVE,  2'd1, 32'sd0,       5'd1,  1'b0, REPLY_QUIET},
            '{MODE_WRITE, 2'd2, 32'sh1000,    5'd15, 1'b0, REPLY_QUIET},
            '{MODE_WRITE, 2'd2, 32'shA5A5A5A5, 5'd1, 1'b1,
              '{32'sd0, STS_OVERWRITE, MOVE_NONE, 32'd1}},
            '{MODE_MOVE,  2'd2, 32'sd0,       5'd1,  1'b0, REPLY_QUIET},
            '{MODE_CLEAR, 2'd2, 32'sd0,       5'd1,  1'b1, REPLY_QUIET},
            '{MODE_READ,  2'd2, 32'sd0,       5'd1,  1'b1, REPLY_EMPTY},
            '{MODE_CLEAR, 2'd3, 32'sd0,       5'd1,  1'b1, REPLY_QUIET}
        };

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (opening_plan[r]) begin
            for (int k = 0; k < opening_plan[r].reps; k++) begin
                send_beat(opening_plan[r].op, opening_plan[r].chan,
                          opening_plan[r].word + k, opening_plan[r].fixed,
                          opening_plan[r].reply);
            end
        end
        opening_beats = beats_sent;

        // Most beats come in bursts on one channel so that channels fill up,
        // overwrite and drain; the rest are scattered single commands.
        while (beats_sent < opening_beats + RANDOM_BEATS) begin
            rel = beats_sent - opening_beats;
            gaps_on = !(rel >= 250 && rel < 400);
            ch = CHAN_W'($urandom_range(0, FIFO_CHANS - 1));
            style = $urandom_range(0, 4);
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    burst = $urandom_range(1, 20);
                    repeat (burst) send_beat(MODE_WRITE, ch, pick_word(style), 1'b0, '0);
                    if ($urandom_range(0, 1) == 1) begin
                        send_beat(MODE_MOVE, ch, $urandom, 1'b0, '0);
                    end
                end
                3, 4: begin
                    burst = $urandom_range(1, 18);
                    repeat (burst) send_beat(MODE_READ, ch, $urandom, 1'b0, '0);
                end
                5: send_beat(MODE_MOVE, ch, $urandom, 1'b0, '0);
                6: begin
                    op = ($urandom_range(0, 2) == 0) ? MODE_CLEAR : MODE_MOVE;
                    send_beat(op, ch, $urandom, 1'b0, '0);
                end
                default: begin
                    burst = $urandom_range(1, 6);
                    repeat (burst) begin
                        op = t_mode'($urandom_range(0, 3));
                        if (op == MODE_CLEAR && $urandom_range(0, 3) != 0) begin
                            op = MODE_READ;
                        end
                        send_beat(op, CHAN_W'($urandom_range(0, FIFO_CHANS - 1)),
                                  pick_word(4), 1'b0, '0);
                    end
                end
            endcase
        end
        cmd.valid <= 1'b0;

        while (owed_replies.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fault_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
